>>> sv/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  // Payload widths of the two channels.
  localparam int ModeW     = 2;
  localparam int CharW     = 8;
  localparam int CellIdxW  = 11;
  localparam int CellWordW = 16;
  localparam int CurColW   = 7;
  localparam int CurRowW   = 5;

  // Configuration port.
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 4;

  localparam logic [CfgIdxW-1:0] REG_TEXT_COLOR = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_BG_COLOR   = 1'd1;

  // Operation codes carried in the mode field.
  localparam logic [ModeW-1:0] MODE_WRITE = 2'd0;
  localparam logic [ModeW-1:0] MODE_CLEAR = 2'd1;
  localparam logic [ModeW-1:0] MODE_READ  = 2'd2;

  // Character codes.
  localparam logic [CharW-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CharW-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CharW-1:0] HIGH_CHAR    = 8'h80;

  // Contents of every cell after reset: a blank, white on black.
  localparam logic [CellWordW-1:0] RESET_BLANK = 16'h0F20;

  localparam logic [CfgDataW-1:0] TEXT_COLOR_RESET = 4'd15;
  localparam logic [CfgDataW-1:0] BG_COLOR_RESET   = 4'd0;

  typedef struct packed {
    logic [ModeW-1:0]    mode;
    logic [CharW-1:0]    char_code;
    logic [CellIdxW-1:0] cell_index;
  } in_beat_t;

  typedef struct packed {
    logic [CellWordW-1:0] cell_word;
    logic [CurColW-1:0]   cursor_col;
    logic [CurRowW-1:0]   cursor_row;
  } out_beat_t;

endpackage

`default_nettype wire

>>> sv/tcw_in_if.sv
`default_nettype none

interface tcw_in_if;
  logic               valid;
  logic               ready;
  tcw_pkg::in_beat_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/tcw_out_if.sv
`default_nettype none

interface tcw_out_if;
  logic               valid;
  logic               ready;
  tcw_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/tcw_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module tcw_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> sv/text_console_char_writer_unit.sv
// Flow: a character or control byte goes from idle to the hand-over state, which loads
//   the result beat; a read passes RDWAIT first, a scroll COPY then FILL, a clear FILL.
// Throughput: one item at a time; the next input beat is taken as soon as the previous
//   result sits in the output register, even if that beat is not yet taken.
// Reset: rst_ni is asynchronous, active low. After release the block sweeps the cell RAM
//   with blanks, and takes no input beat until done.
`default_nettype none

module text_console_char_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tcw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [tcw_pkg::CfgDataW-1:0]  cfg_data_i,
  tcw_in_if.sink                             in_i,
  tcw_out_if.source                          out_o
);

  // Geometry of the cell store. The store is kept row by row, so a cell lives at
  // row * COLUMNS + column.
  localparam int CellCount = COLUMNS * ROWS;
  localparam int AddrW     = $clog2(CellCount);
  localparam int ColW      = $clog2(COLUMNS);
  localparam int RowW      = $clog2(ROWS);

  localparam logic [AddrW-1:0] LastAddr   = AddrW'(CellCount - 1);
  localparam logic [AddrW-1:0] SecondRow  = AddrW'(COLUMNS);
  localparam logic [AddrW-1:0] BottomRow  = AddrW'((ROWS - 1) * COLUMNS);
  localparam logic [AddrW-1:0] RowStride  = AddrW'(COLUMNS);
  localparam logic [ColW-1:0]  LastCol    = ColW'(COLUMNS - 1);
  localparam logic [RowW-1:0]  LastRow    = RowW'(ROWS - 1);

  // Sequencer states. INIT is the blanking sweep after reset, COPY moves every row but
  // the top one up by one during a scroll, FILL writes a run of blanks (bottom row or
  // whole screen), RDWAIT waits out the RAM read latency, DONE hands the result over.
  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_RDWAIT = 6'b000100,
    S_COPY   = 6'b001000,
    S_FILL   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [AddrW-1:0] fill_addr_q, fill_addr_d;
  logic [15:0]      fill_word_q, fill_word_d;
  logic [AddrW-1:0] rd_addr_q, rd_addr_d;
  logic             wr_pend_q, wr_pend_d;
  logic [AddrW-1:0] wr_addr_q, wr_addr_d;
  logic [15:0]      word_q, word_d;
  logic [ColW-1:0]  cur_col_q, cur_col_d;
  logic [RowW-1:0]  cur_row_q, cur_row_d;
  logic [3:0]       text_color_q;
  logic [3:0]       bg_color_q;
  logic             out_valid_q, out_valid_d;
  tcw_pkg::out_beat_t out_data_q, out_data_d;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [15:0]      ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [15:0]      ram_rdata;

  logic [7:0]       attr;
  logic [15:0]      blank_word;
  logic [AddrW-1:0] cursor_addr;
  logic             next_row;

  assign attr        = {bg_color_q, text_color_q};
  assign blank_word  = {attr, tcw_pkg::BLANK_CHAR};
  assign cursor_addr = AddrW'(cur_row_q * COLUMNS) + AddrW'(cur_col_q);

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  tcw_ram #(
    .Width (16),
    .Depth (CellCount)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    fill_addr_d = fill_addr_q;
    fill_word_d = fill_word_q;
    rd_addr_d   = rd_addr_q;
    wr_pend_d   = wr_pend_q;
    wr_addr_d   = wr_addr_q;
    word_d      = word_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = fill_addr_q;
    ram_wdata   = fill_word_q;
    ram_raddr   = rd_addr_q;
    in_i.ready  = 1'b0;
    next_row    = 1'b0;

    // A result beat leaves the output register whenever the sink takes it.
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = tcw_pkg::RESET_BLANK;
        if (fill_addr_q == LastAddr) begin
          state_d = S_IDLE;
        end else begin
          fill_addr_d = fill_addr_q + 1'b1;
        end
      end

      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          word_d  = '0;
          state_d = S_DONE;
          case (in_i.data.mode)
            tcw_pkg::MODE_WRITE: begin
              if (in_i.data.char_code == tcw_pkg::NEWLINE_CHAR) begin
                cur_col_d = '0;
                next_row  = 1'b1;
              end else if (in_i.data.char_code >= tcw_pkg::BLANK_CHAR &&
                           in_i.data.char_code < tcw_pkg::HIGH_CHAR) begin
                ram_we    = 1'b1;
                ram_waddr = cursor_addr;
                ram_wdata = {attr, in_i.data.char_code};
                if (cur_col_q == LastCol) begin
                  cur_col_d = '0;
                  next_row  = 1'b1;
                end else begin
                  cur_col_d = cur_col_q + 1'b1;
                end
              end
            end
            tcw_pkg::MODE_CLEAR: begin
              fill_addr_d = '0;
              fill_word_d = blank_word;
              cur_col_d   = '0;
              cur_row_d   = '0;
              state_d     = S_FILL;
            end
            tcw_pkg::MODE_READ: begin
              if (32'(in_i.data.cell_index) < 32'(CellCount)) begin
                ram_raddr = AddrW'(in_i.data.cell_index);
                state_d   = S_RDWAIT;
              end
            end
            default: begin
            end
          endcase

          // Moving below the last row starts a scroll: copy rows up, then blank
          // the bottom row. The cursor stays on the last row.
          if (next_row) begin
            if (cur_row_q == LastRow) begin
              rd_addr_d   = SecondRow;
              wr_pend_d   = 1'b0;
              fill_addr_d = BottomRow;
              fill_word_d = blank_word;
              state_d     = S_COPY;
            end else begin
              cur_row_d = cur_row_q + 1'b1;
            end
          end
        end
      end

      S_RDWAIT: begin
        word_d  = ram_rdata;
        state_d = S_DONE;
      end

      S_COPY: begin
        // Read one cell a cycle; the word read last cycle is written one row up.
        ram_we    = wr_pend_q;
        ram_waddr = wr_addr_q;
        ram_wdata = ram_rdata;
        wr_pend_d = 1'b1;
        wr_addr_d = rd_addr_q - RowStride;
        if (rd_addr_q == LastAddr) begin
          state_d = S_FILL;
        end else begin
          rd_addr_d = rd_addr_q + 1'b1;
        end
      end

      S_FILL: begin
        ram_we = 1'b1;
        if (wr_pend_q) begin
          // Last copied cell of a scroll still has to land.
          ram_waddr = wr_addr_q;
          ram_wdata = ram_rdata;
          wr_pend_d = 1'b0;
        end else if (fill_addr_q == LastAddr) begin
          state_d = S_DONE;
        end else begin
          fill_addr_d = fill_addr_q + 1'b1;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d           = 1'b1;
          out_data_d.cell_word  = word_q;
          out_data_d.cursor_col = tcw_pkg::CurColW'(cur_col_q);
          out_data_d.cursor_row = tcw_pkg::CurRowW'(cur_row_q);
          state_d               = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      fill_addr_q  <= '0;
      wr_pend_q    <= 1'b0;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      out_valid_q  <= 1'b0;
      text_color_q <= tcw_pkg::TEXT_COLOR_RESET;
      bg_color_q   <= tcw_pkg::BG_COLOR_RESET;
    end else begin
      state_q     <= state_d;
      fill_addr_q <= fill_addr_d;
      wr_pend_q   <= wr_pend_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == tcw_pkg::REG_TEXT_COLOR) begin
          text_color_q <= cfg_data_i;
        end else if (cfg_idx_i == tcw_pkg::REG_BG_COLOR) begin
          bg_color_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fill_word_q <= fill_word_d;
    rd_addr_q   <= rd_addr_d;
    wr_addr_q   <= wr_addr_d;
    word_q      <= word_d;
    out_data_q  <= out_data_d;
  end

  // The cursor never leaves the screen.
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cur_col_q) < 32'(COLUMNS)) && (32'(cur_row_q) < 32'(ROWS)))
    else $error("cursor outside the screen");

  // Every RAM write lands inside the cell store.
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr <= LastAddr))
    else $error("cell write beyond the store");

  // A new result beat is only loaded from the hand-over state.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside the hand-over state");

  // A scroll always ends with the bottom-row fill, never straight in idle.
  a_copy_then_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY && rd_addr_q == LastAddr) |=> (state_q == S_FILL && wr_pend_q))
    else $error("scroll copy did not hand over to the fill");

  // The copy pipeline never has a write pending outside a scroll.
  a_pend_only_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> (state_q == S_COPY || state_q == S_FILL))
    else $error("stray pending copy write");

endmodule

`default_nettype wire
